// File: sv/udec_pkg.sv
// shared types, character constants and hex helpers for the url percent decoder
package udec_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  localparam int unsigned MAX_RESULTS = 3;

  // one encoded byte as held in the input register
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // the decoded bytes produced by one encoded byte
  typedef struct packed {
    logic [1:0]                        count;
    logic [MAX_RESULTS-1:0][7:0]       data;
    logic                              last;
  } result_t;

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // value of a hex digit; only meaningful when is_hex holds
  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [3:0] v;
    if (c[6]) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = c[3:0];
    end
    return v;
  endfunction

endpackage

// File: sv/udec_in_stage.sv
// input register: holds one encoded byte until the decode stage takes it
module udec_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              free,
  output logic              take,
  output udec_pkg::item_t   item
);

  logic held;

  assign take     = held && free;
  assign in_ready = !held || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data <= in_byte;
      item.last <= in_last;
    end
  end

endmodule

// File: sv/udec_decode.sv
// escape tracking and decode of one byte into up to three result bytes
module udec_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  udec_pkg::item_t   item,
  output udec_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIG
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_hex_char;
  logic [7:0] plain;
  logic       plain_hold;
  logic       hex;

  assign hex        = udec_pkg::is_hex(item.data);
  assign plain      = (item.data == udec_pkg::CH_PLUS) ? udec_pkg::CH_SPACE : item.data;
  assign plain_hold = (item.data == udec_pkg::CH_PERCENT) && !item.last;

  always_comb begin
    res.count  = 2'd0;
    res.data   = '0;
    res.last   = item.last;
    phase_next = PH_IDLE;
    unique case (phase)
      PH_PCT: begin
        if (hex && !item.last) begin
          phase_next = PH_DIG;
        end else if (hex) begin
          res.count   = 2'd2;
          res.data[0] = udec_pkg::CH_PERCENT;
          res.data[1] = item.data;
        end else if (plain_hold) begin
          res.count   = 2'd1;
          res.data[0] = udec_pkg::CH_PERCENT;
          phase_next  = PH_PCT;
        end else begin
          res.count   = 2'd2;
          res.data[0] = udec_pkg::CH_PERCENT;
          res.data[1] = plain;
        end
      end
      PH_DIG: begin
        if (hex) begin
          res.count   = 2'd1;
          res.data[0] = {udec_pkg::hex_val(held_hex_char), udec_pkg::hex_val(item.data)};
        end else if (plain_hold) begin
          res.count   = 2'd2;
          res.data[0] = udec_pkg::CH_PERCENT;
          res.data[1] = held_hex_char;
          phase_next  = PH_PCT;
        end else begin
          res.count   = 2'd3;
          res.data[0] = udec_pkg::CH_PERCENT;
          res.data[1] = held_hex_char;
          res.data[2] = plain;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        if (plain_hold) begin
          phase_next = PH_PCT;
        end else begin
          res.count   = 2'd1;
          res.data[0] = plain;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      held_hex_char <= 8'h00;
    end else if (take) begin
      phase <= phase_next;
      if ((phase == PH_PCT) && (phase_next == PH_DIG)) begin
        held_hex_char <= item.data;
      end
    end
  end

endmodule

// File: sv/udec_out_buf.sv
// result register: holds the bytes of one decoded item and hands them out in order
module udec_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  udec_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  logic [1:0]                                  rem;
  logic [1:0]                                  idx;
  logic [udec_pkg::MAX_RESULTS-1:0][7:0]       data;
  logic                                        last;

  assign out_valid = (rem != 2'd0);
  assign free      = (rem == 2'd0) || ((rem == 2'd1) && out_ready);
  assign out_last  = last && (rem == 2'd1);

  always_comb begin
    unique case (idx)
      2'd1:    out_byte = data[1];
      2'd2:    out_byte = data[2];
      default: out_byte = data[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      rem <= res.count;
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      rem <= rem - 2'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res.data;
      last <= res.last;
    end
  end

endmodule

// File: sv/url_percent_decoder.sv
// top level of the streaming url percent decoder
//
// Streaming url decoder, one encoded byte in per transfer, decoded bytes out
// one per transfer. '+' becomes a space, '%' with two hex digits (either case)
// becomes the encoded byte, and an escape that does not complete is passed
// through literally before the byte that broke it is handled as usual (so a
// second '%' opens a new escape). in_last flushes any held '%' or digit and
// out_last marks the final decoded byte; every final byte gives at least one
// output. Each accepted byte goes into an input register, is decoded against
// the escape state into up to three result bytes when the result register
// can load, and those sit in the result register, which drains one byte per
// cycle while out_ready is high. With no back pressure a byte is taken every
// cycle as long as each byte yields at most one output; a byte that yields
// two or three outputs (a broken escape) holds the result register until its
// bytes are out, and the input side waits meanwhile.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  udec_pkg::item_t   item;
  udec_pkg::result_t res;
  logic              take;   // input register moves into decode this cycle
  logic              free;   // result register can load this cycle

  // input register
  udec_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .free     (free),
    .take     (take),
    .item     (item)
  );

  // escape state and decode
  udec_decode u_dec (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .res  (res)
  );

  // result register, drained one byte per transfer
  udec_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// File: sv/udec_checker.sv
// port-level checks for the url percent decoder and their bind
module udec_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a stalled output transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output changed while stalled");

  // nothing is offered right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // with no output pending the input side must never block
  a_no_deadlock: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a final byte taken while nothing is pending makes the output valid
  a_last_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last && !out_valid && !$past(in_valid && in_ready)
    |=> ##1 out_valid)
    else $error("final byte produced no output");

endmodule

bind url_percent_decoder udec_checker u_udec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
